// ----- hdl/ddo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg
// shared types, constants and the arctangent table of the odometry block
// ----------------------------------------------------------------------------
package ddo_pkg;

	localparam int unsigned CordicStepsDefault = 24;
	localparam int unsigned PositionBitsDefault = 48;
	localparam int unsigned CW = 34;

	localparam logic [31:0] InvSepReset = 32'd218453;
	localparam logic [29:0] InvTwoPiQ32 = 30'd683565276;
	localparam logic signed [CW-1:0] CordicGain = 34'sh026DD3B6A;
	localparam logic signed [CW-1:0] UnitQ30 = 34'sh040000000;

	typedef struct packed {
		logic valid;
		logic flip;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} ddo_cell_t;

	function automatic logic [31:0] atan_bam(input logic [4:0] k);
		logic [31:0] r;
		case (k)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/ddo_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_if
// valid/ready channels for wheel speed transactions and pose transactions
// ----------------------------------------------------------------------------
interface ddo_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] left_speed;
	logic signed [31:0] right_speed;
	logic [15:0] time_step;
	modport source(output valid, left_speed, right_speed, time_step, input ready);
	modport sink(input valid, left_speed, right_speed, time_step, output ready);
endinterface

interface ddo_out_if;
	logic valid;
	logic ready;
	logic signed [47:0] pos_x;
	logic signed [47:0] pos_y;
	logic signed [31:0] heading_angle;
	logic signed [17:0] quat_z;
	logic signed [17:0] quat_w;
	logic signed [31:0] linear_speed;
	logic signed [31:0] turn_rate;
	logic updated;
	modport source(output valid, pos_x, pos_y, heading_angle, quat_z, quat_w,
		linear_speed, turn_rate, updated, input ready);
	modport sink(input valid, pos_x, pos_y, heading_angle, quat_z, quat_w,
		linear_speed, turn_rate, updated, output ready);
endinterface
`default_nettype wire

// ----- hdl/diff_drive_odometry.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_odometry
// wheel speeds to pose by midpoint integration, with heading quaternion
// ----------------------------------------------------------------------------
// channel   dir  transaction
// in_ch     in   left_speed, right_speed, time_step
// out_ch    out  pose, quaternion, speeds, updated flag
// cfg       in   inv_wheel_separation write, cfg_we / cfg_wdata
//
// one transaction at a time: a nonzero time step makes two passes through the
// cordic cell row, a zero one only the second. in_ch.ready is high only
// while idle. a stalled result holds the block before the output register.
// reset clears pose and speeds.
// ----------------------------------------------------------------------------
module diff_drive_odometry #(
	parameter int unsigned CORDIC_STEPS = ddo_pkg::CordicStepsDefault,
	parameter int unsigned POSITION_BITS = ddo_pkg::PositionBitsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	ddo_in_if.sink in_ch,
	ddo_out_if.source out_ch,
	input wire logic cfg_we,
	input wire logic [31:0] cfg_wdata
);
	import ddo_pkg::*;

	localparam int unsigned PB = POSITION_BITS;
	localparam int unsigned SW = ((PB > 37) ? PB : 37) + 1;
	localparam logic signed [SW-1:0] PMAX = {{(SW-PB+1){1'b0}}, {(PB-1){1'b1}}};
	localparam logic signed [SW-1:0] PMIN = ~PMAX;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_MULW = 11'b00000000010,
		S_MULP = 11'b00000000100,
		S_MULB = 11'b00000001000,
		S_ANG = 11'b00000010000,
		S_CW1 = 11'b00000100000,
		S_POS1 = 11'b00001000000,
		S_POS2 = 11'b00010000000,
		S_POS3 = 11'b00100000000,
		S_CW2 = 11'b01000000000,
		S_DONE = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [31:0] inv_q;
	logic signed [PB-1:0] x_q, y_q;
	logic [31:0] head_q;
	logic signed [31:0] lin_q, turn_q;
	logic signed [31:0] v_q, w_q;
	logic signed [32:0] diff_q;
	logic [15:0] dt_q;
	logic [47:0] p_q;
	logic [61:0] hk_q;
	logic [29:0] lk_q;
	logic [31:0] delta_q;
	logic signed [CW-1:0] c_q, s_q;
	logic signed [35:0] ax_q, ay_q;
	logic signed [36:0] dx_q, dy_q;
	logic issue_q;
	logic [31:0] ang_q;
	logic upd_q;

	logic cdone;
	logic signed [CW-1:0] ccos, csin;

	logic [32:0] mag;
	logic [64:0] prod_w;
	logic [48:0] wm;
	logic signed [31:0] wsat;
	logic [31:0] wabs;
	logic [62:0] bsum;
	logic [47:0] bm;
	logic [31:0] half;
	logic signed [65:0] px, py;
	logic signed [16:0] dts;
	logic signed [52:0] pdx, pdy;
	logic signed [SW-1:0] sx, sy;
	logic signed [CW:0] rz, rw;
	logic signed [17:0] qz, qw;
	logic [31:0] head_n;

	ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(issue_q),
		.angle(ang_q),
		.done(cdone),
		.cos_v(ccos),
		.sin_v(csin)
	);

	assign in_ch.ready = (state_q == S_IDLE);

	always_comb begin
		mag = diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
		prod_w = 65'(mag) * 65'(inv_q);
		wm = prod_w[64:16];
		if (diff_q[32]) begin
			wsat = (wm > 49'h80000000) ? 32'sh80000000 : -signed'(wm[31:0]);
		end else begin
			wsat = (wm > 49'h7FFFFFFF) ? 32'sh7FFFFFFF : signed'(wm[31:0]);
		end
		wabs = w_q[31] ? 32'(-w_q) : 32'(w_q);
		bsum = 63'(hk_q) + 63'(lk_q);
		bm = {1'b0, bsum[62:16]};
		half = bm[32:1];
		px = 66'(v_q) * 66'(c_q);
		py = 66'(v_q) * 66'(s_q);
		dts = signed'({1'b0, dt_q});
		pdx = 53'(ax_q) * 53'(dts);
		pdy = 53'(ay_q) * 53'(dts);
		sx = SW'(x_q) + SW'(dx_q);
		sy = SW'(y_q) + SW'(dy_q);
		if (sx > PMAX) sx = PMAX;
		if (sx < PMIN) sx = PMIN;
		if (sy > PMAX) sy = PMAX;
		if (sy < PMIN) sy = PMIN;
		head_n = head_q + delta_q;
		rz = (CW+1)'(s_q) + (CW+1)'(signed'(15'sd8192)) >>> 14;
		rw = (CW+1)'(c_q) + (CW+1)'(signed'(15'sd8192)) >>> 14;
		qz = (rz > 35'sd65536) ? 18'sd65536 : ((rz < -35'sd65536) ? -18'sd65536 : rz[17:0]);
		qw = (rw > 35'sd65536) ? 18'sd65536 : ((rw < -35'sd65536) ? -18'sd65536 : rw[17:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			inv_q <= InvSepReset;
			x_q <= '0;
			y_q <= '0;
			head_q <= '0;
			lin_q <= '0;
			turn_q <= '0;
			issue_q <= 1'b0;
			out_ch.valid <= 1'b0;
		end else begin
			issue_q <= 1'b0;
			if (cfg_we) inv_q <= cfg_wdata;
			if (out_ch.valid && out_ch.ready && state_q != S_DONE) out_ch.valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) state_q <= S_MULW;
				end
				S_MULW: begin
					if (dt_q == '0) begin
						issue_q <= 1'b1;
						state_q <= S_CW2;
					end else begin
						state_q <= S_MULP;
					end
				end
				S_MULP: state_q <= S_MULB;
				S_MULB: state_q <= S_ANG;
				S_ANG: begin
					issue_q <= 1'b1;
					state_q <= S_CW1;
				end
				S_CW1: begin
					if (cdone) state_q <= S_POS1;
				end
				S_POS1: state_q <= S_POS2;
				S_POS2: state_q <= S_POS3;
				S_POS3: begin
					x_q <= sx[PB-1:0];
					y_q <= sy[PB-1:0];
					head_q <= head_n;
					lin_q <= v_q;
					turn_q <= w_q;
					issue_q <= 1'b1;
					state_q <= S_CW2;
				end
				S_CW2: begin
					if (cdone) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_ch.valid || out_ch.ready) begin
						out_ch.valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			diff_q <= 33'(in_ch.right_speed) - 33'(in_ch.left_speed);
			v_q <= 32'((33'(in_ch.left_speed) + 33'(in_ch.right_speed)) >>> 1);
			dt_q <= in_ch.time_step;
			upd_q <= (in_ch.time_step != '0);
		end
		if (state_q == S_MULW) begin
			w_q <= wsat;
			ang_q <= {head_q[31], head_q[31:1]};
		end
		if (state_q == S_MULP) p_q <= 48'(wabs) * 48'(dt_q);
		if (state_q == S_MULB) begin
			hk_q <= 62'(p_q[47:16]) * 62'(InvTwoPiQ32);
			lk_q <= 30'((46'(p_q[15:0]) * 46'(InvTwoPiQ32)) >> 16);
		end
		if (state_q == S_ANG) begin
			delta_q <= w_q[31] ? -bm[31:0] : bm[31:0];
			ang_q <= head_q + (w_q[31] ? -half : half);
		end
		if (cdone) begin
			c_q <= ccos;
			s_q <= csin;
		end
		if (state_q == S_POS1) begin
			ax_q <= px[65:30];
			ay_q <= py[65:30];
		end
		if (state_q == S_POS2) begin
			dx_q <= pdx[52:16];
			dy_q <= pdy[52:16];
		end
		if (state_q == S_POS3) ang_q <= {head_n[31], head_n[31:1]};
		if (state_q == S_DONE && (!out_ch.valid || out_ch.ready)) begin
			out_ch.pos_x <= 48'(x_q);
			out_ch.pos_y <= 48'(y_q);
			out_ch.heading_angle <= head_q;
			out_ch.quat_z <= qz;
			out_ch.quat_w <= qw;
			out_ch.linear_speed <= lin_q;
			out_ch.turn_rate <= turn_q;
			out_ch.updated <= upd_q;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/ddo_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_cell
// one cordic rotation step, registered, passed to the next cell every cycle
// ----------------------------------------------------------------------------
module ddo_cell #(
	parameter int unsigned IDX = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire ddo_pkg::ddo_cell_t din,
	output ddo_pkg::ddo_cell_t dout
);
	import ddo_pkg::*;

	localparam logic [4:0] K = 5'(IDX);

	logic signed [CW-1:0] ys;
	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] at;
	ddo_cell_t nxt;

	assign ys = din.y >>> K;
	assign xs = din.x >>> K;
	assign at = CW'(signed'({1'b0, atan_bam(K)}));

	always_comb begin
		nxt = din;
		if (!din.z[CW-1]) begin
			nxt.x = din.x - ys;
			nxt.y = din.y + xs;
			nxt.z = din.z - at;
		end else begin
			nxt.x = din.x + ys;
			nxt.y = din.y - xs;
			nxt.z = din.z + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else begin
			dout <= nxt;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/ddo_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_cordic
// quadrant fold, row of rotation cells, clamp and unfold of cosine and sine
// ----------------------------------------------------------------------------
module ddo_cordic #(
	parameter int unsigned CORDIC_STEPS = ddo_pkg::CordicStepsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [31:0] angle,
	output logic done,
	output logic signed [ddo_pkg::CW-1:0] cos_v,
	output logic signed [ddo_pkg::CW-1:0] sin_v
);
	import ddo_pkg::*;

	ddo_cell_t link [CORDIC_STEPS+1];
	logic [31:0] shifted;
	logic fold;
	logic [31:0] folded;
	logic signed [CW-1:0] xc;
	logic signed [CW-1:0] yc;

	assign shifted = angle + 32'h40000000;
	assign fold = shifted[31];
	assign folded = fold ? angle + 32'h80000000 : angle;

	always_comb begin
		link[0].valid = start;
		link[0].flip = fold;
		link[0].x = CordicGain;
		link[0].y = '0;
		link[0].z = CW'(signed'(folded));
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		ddo_cell #(.IDX(i)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.din(link[i]),
			.dout(link[i+1])
		);
	end

	always_comb begin
		xc = link[CORDIC_STEPS].x;
		yc = link[CORDIC_STEPS].y;
		if (xc > UnitQ30) xc = UnitQ30;
		if (xc < -UnitQ30) xc = -UnitQ30;
		if (yc > UnitQ30) yc = UnitQ30;
		if (yc < -UnitQ30) yc = -UnitQ30;
		cos_v = link[CORDIC_STEPS].flip ? -xc : xc;
		sin_v = link[CORDIC_STEPS].flip ? -yc : yc;
		done = link[CORDIC_STEPS].valid;
	end
endmodule
`default_nettype wire

// ----- hdl/ddo_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_checker
// port level checks of the odometry block, bound to the top level
// ----------------------------------------------------------------------------
module ddo_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic signed [17:0] quat_z,
	input wire logic signed [17:0] quat_w,
	input wire logic [47:0] pos_x
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x))
		else $error("result dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while busy");

	a_quat_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> quat_z <= 18'sd65536 && quat_z >= -18'sd65536
			&& quat_w <= 18'sd65536 && quat_w >= -18'sd65536)
		else $error("quaternion out of range");
endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.quat_z(out_ch.quat_z),
	.quat_w(out_ch.quat_w),
	.pos_x(out_ch.pos_x)
);
`default_nettype wire

// ----- dv/tb_diff_drive_odometry.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diff_drive_odometry
// self-checking bench for the odometry block: a table of directed wheel speed
// transactions, then random ones, each pose transaction checked field by field
// against a behavioral predictor; random idling on both channels
// ----------------------------------------------------------------------------
module tb_diff_drive_odometry;
	import ddo_pkg::*;

	typedef struct packed {
		logic [47:0] px;
		logic [47:0] py;
		logic [31:0] hd;
		logic [17:0] qz;
		logic [17:0] qw;
		logic [31:0] lin;
		logic [31:0] trn;
		logic upd;
	} pose_t;

	typedef struct {
		logic [31:0] l;
		logic [31:0] r;
		logic [15:0] dt;
		bit known;
		pose_t p;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_wdata;
	ddo_in_if in_ch();
	ddo_out_if out_ch();

	diff_drive_odometry uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [31:0] inv_sep;
	longint pose_x, pose_y;
	logic [31:0] pose_hd;
	logic [31:0] pose_lin, pose_trn;

	pose_t pose_q[$];
	int mismatches = 0;
	int checked = 0;
	int sent = 0;
	bit hold_long = 0;
	bit no_idle = 0;
	row_t dir_rows[$];

	function automatic logic [31:0] atan_tab(int k);
		logic [31:0] t[32] = '{
			32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
			32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
			32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
			32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
			32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
			32'h00000001, 32'h00000000};
		return t[k];
	endfunction

	task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
		bit flip;
		longint x, y, z, nx;
		logic [31:0] a;
		flip = 0;
		a = ang;
		if (a + 32'h40000000 >= 32'h80000000) begin
			a = a + 32'h80000000;
			flip = 1;
		end
		x = 64'sh26DD3B6A;
		y = 0;
		z = longint'($signed(a));
		for (int i = 0; i < CordicStepsDefault; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - longint'(atan_tab(i));
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + longint'(atan_tab(i));
			end
			x = nx;
		end
		if (x > (64'sd1 << 30)) x = 64'sd1 << 30;
		if (x < -(64'sd1 << 30)) x = -(64'sd1 << 30);
		if (y > (64'sd1 << 30)) y = 64'sd1 << 30;
		if (y < -(64'sd1 << 30)) y = -(64'sd1 << 30);
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint to_q16(longint v);
		longint r;
		r = (v + 8192) >>> 14;
		if (r > 65536) r = 65536;
		if (r < -65536) r = -65536;
		return r;
	endfunction

	function automatic longint sat_add(longint p, longint d);
		longint pmax, pmin;
		pmax = (64'sd1 <<< (PositionBitsDefault - 1)) - 1;
		pmin = -pmax - 1;
		if (d > 0 && p > pmax - d) return pmax;
		if (d < 0 && p < pmin - d) return pmin;
		return p + d;
	endfunction

	function automatic longint travel(longint v, longint trig, longint dt);
		longint a;
		a = (v * trig) >>> 30;
		return (a * dt) >>> 16;
	endfunction

	task automatic integrate(input logic [31:0] ls, input logic [31:0] rs,
		input logic [15:0] dt, output pose_t p);
		longint l, r, diff, w, v, c, s, qz, qw;
		logic [63:0] mag, wm, pr, hi, lo, bm;
		logic [31:0] delta, half;
		l = longint'($signed(ls));
		r = longint'($signed(rs));
		if (dt != 0) begin
			diff = r - l;
			mag = diff < 0 ? -diff : diff;
			wm = (mag * {32'd0, inv_sep}) >> 16;
			v = (l + r) >>> 1;
			if (diff < 0) w = wm > 64'h80000000 ? -64'sd2147483648 : -longint'(wm);
			else w = wm > 64'h7FFFFFFF ? 64'sd2147483647 : longint'(wm);
			pr = (w < 0 ? -w : w) * longint'(dt);
			hi = pr >> 16;
			lo = pr & 64'hFFFF;
			bm = (hi * 64'd683565276 + ((lo * 64'd683565276) >> 16)) >> 16;
			delta = bm[31:0];
			half = bm[32:1];
			if (w < 0) begin
				delta = -delta;
				half = -half;
			end
			rotate(pose_hd + half, c, s);
			pose_x = sat_add(pose_x, travel(v, c, dt));
			pose_y = sat_add(pose_y, travel(v, s, dt));
			pose_hd = pose_hd + delta;
			pose_lin = v[31:0];
			pose_trn = w[31:0];
		end
		rotate({pose_hd[31], pose_hd[31:1]}, c, s);
		qz = to_q16(s);
		qw = to_q16(c);
		p.px = pose_x[47:0];
		p.py = pose_y[47:0];
		p.hd = pose_hd;
		p.qz = qz[17:0];
		p.qw = qw[17:0];
		p.lin = pose_lin;
		p.trn = pose_trn;
		p.upd = dt != 0;
	endtask

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#80ms;
		$display("tb_diff_drive_odometry: errors");
		$finish;
	end

	task automatic send(input logic [31:0] l, input logic [31:0] r, input logic [15:0] dt,
		input bit known, input pose_t kp);
		pose_t p;
		while (!no_idle && $urandom_range(99) < 17) begin
			in_ch.valid <= 0;
			@(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.left_speed <= l;
		in_ch.right_speed <= r;
		in_ch.time_step <= dt;
		do @(posedge clk); while (!in_ch.ready);
		integrate(l, r, dt, p);
		if (known && p != kp) begin
			mismatches++;
			if (mismatches <= 10)
				$display("directed row %0d: predictor disagrees with table", sent);
		end
		pose_q.push_back(p);
		sent++;
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (pose_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_sep(input logic [31:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		inv_sep = v;
	endtask

	function automatic logic [31:0] rnd_speed();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'(int'($urandom_range(0, 262144)) - 131072);
			2: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
			default: return 32'(int'($urandom_range(0, 8192)) - 4096);
		endcase
	endfunction

	function automatic logic [15:0] rnd_dt();
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// output checker
	always @(posedge clk) begin
		pose_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pose_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected pose transaction");
			end else begin
				e = pose_q.pop_front();
				checked++;
				if (out_ch.pos_x !== e.px || out_ch.pos_y !== e.py ||
					out_ch.heading_angle !== e.hd || out_ch.quat_z !== e.qz ||
					out_ch.quat_w !== e.qw || out_ch.linear_speed !== e.lin ||
					out_ch.turn_rate !== e.trn || out_ch.updated !== e.upd) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch %0d: exp x=%h y=%h h=%h qz=%h qw=%h v=%h w=%h u=%b got x=%h y=%h h=%h qz=%h qw=%h v=%h w=%h u=%b",
							checked, e.px, e.py, e.hd, e.qz, e.qw, e.lin, e.trn, e.upd,
							out_ch.pos_x, out_ch.pos_y, out_ch.heading_angle, out_ch.quat_z,
							out_ch.quat_w, out_ch.linear_speed, out_ch.turn_rate, out_ch.updated);
				end
			end
		end
	end

	// receiver
	initial begin
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_ch.ready <= 0;
				repeat (600) @(posedge clk);
				hold_long = 0;
			end
			out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 17);
		end
	end

	initial begin
		pose_t z;
		row_t rw;
		logic [31:0] seps[6] = '{32'd1, 32'hFFFFFFFF, 32'd0, 32'd65536, 32'd218453, 32'd1000};
		in_ch.valid = 0;
		in_ch.left_speed = 0;
		in_ch.right_speed = 0;
		in_ch.time_step = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		arst_n = 0;
		inv_sep = InvSepReset;
		pose_x = 0; pose_y = 0; pose_hd = 0; pose_lin = 0; pose_trn = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// zero step right after reset: identity pose
		z = '{48'd0, 48'd0, 32'd0, 18'd0, 18'd65536, 32'd0, 32'd0, 1'b0};
		dir_rows.push_back('{32'h00010000, 32'h00020000, 16'd0, 1, z});
		z.upd = 1;
		dir_rows.push_back('{32'd0, 32'd0, 16'hFFFF, 1, z});
		dir_rows.push_back('{32'h00010000, 32'h00010000, 16'h8000, 0, z});
		dir_rows.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 0, z});
		dir_rows.push_back('{32'h80000000, 32'h80000000, 16'hFFFF, 0, z});
		dir_rows.push_back('{32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 0, z});
		dir_rows.push_back('{32'h7FFFFFFF, 32'h80000000, 16'hFFFF, 0, z});
		dir_rows.push_back('{32'hFFFF0000, 32'h00010000, 16'd1, 0, z});
		dir_rows.push_back('{32'h00100000, 32'h00300000, 16'hFFFF, 0, z});
		dir_rows.push_back('{32'h00100000, 32'h00300000, 16'hFFFF, 0, z});
		dir_rows.push_back('{32'h00100000, 32'h00300000, 16'hFFFF, 0, z});
		dir_rows.push_back('{32'h00300000, 32'h00100000, 16'hFFFF, 0, z});
		dir_rows.push_back('{32'h12345678, 32'hFEDCBA98, 16'd0, 0, z});
		for (int i = 0; i < 12; i++)
			dir_rows.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 0, z});
		foreach (dir_rows[i]) begin
			rw = dir_rows[i];
			send(rw.l, rw.r, rw.dt, rw.known, rw.p);
		end

		for (int ph = 0; ph < 6; ph++) begin
			write_sep(seps[ph]);
			no_idle = (ph == 3);
			if (ph == 2) hold_long = 1;
			for (int i = 0; i < 270; i++)
				send(rnd_speed(), rnd_speed(), rnd_dt(), 0, z);
			if (ph == 4) drain();
		end
		no_idle = 0;
		drain();
		$display("ran %0d wheel speed transactions, %0d pose transactions checked,", sent, checked);
		$display("six wheel separation settings, zero steps, saturation and a long output stall");
		if (mismatches == 0 && pose_q.size() == 0)
			$display("tb_diff_drive_odometry: clean");
		else
			$display("tb_diff_drive_odometry: errors");
		$finish;
	end
endmodule
